>>> sv/gtp_pkg.sv
// ----------------------------------------------------------------------------
// gtp_pkg
// Types, character codes and a helper function shared by the GUID text parser.
// ----------------------------------------------------------------------------
package gtp_pkg;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_LC_A  = 8'h61;
	localparam logic [7:0] CHAR_LC_F  = 8'h66;
	localparam logic [7:0] CHAR_UC_A  = 8'h41;
	localparam logic [7:0] CHAR_UC_F  = 8'h46;
	localparam logic [7:0] CHAR_DASH  = 8'h2d;
	localparam logic [7:0] CHAR_LC_X  = 8'h78;

	localparam logic [2:0] GRP_DATA1  = 3'd0;
	localparam logic [2:0] GRP_DATA2  = 3'd1;
	localparam logic [2:0] GRP_DATA3  = 3'd2;
	localparam logic [2:0] GRP_CLOCK  = 3'd3;
	localparam logic [2:0] GRP_NODE   = 3'd4;

	localparam logic [3:0] NEED_DATA1 = 4'd8;
	localparam logic [3:0] NEED_SHORT = 4'd4;
	localparam logic [3:0] NEED_NODE  = 4'd12;
	localparam logic [3:0] PREFIX_LEN = 4'd2;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_INVALID = 1'b1;

	typedef struct packed {
		logic [2:0]  group_index;
		logic [3:0]  digit_count;
		logic        prefix_seen;
		logic        busy;
		logic [31:0] field1_acc;
		logic [15:0] field2_acc;
		logic [15:0] field3_acc;
		logic [63:0] field4_acc;
	} gtp_state_t;

	typedef struct packed {
		logic        status;
		logic [31:0] data1;
		logic [15:0] data2;
		logic [15:0] data3;
		logic [63:0] data4;
	} gtp_result_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} gtp_hex_t;

	function automatic gtp_hex_t hex_decode(input logic [7:0] c);
		gtp_hex_t h;
		h.valid = 1'b1;
		h.value = 4'd0;
		if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
			h.value = 4'(c - CHAR_ZERO);
		end else if (c inside {[CHAR_LC_A:CHAR_LC_F]}) begin
			h.value = 4'(c - CHAR_LC_A + 8'd10);
		end else if (c inside {[CHAR_UC_A:CHAR_UC_F]}) begin
			h.value = 4'(c - CHAR_UC_A + 8'd10);
		end else begin
			h.valid = 1'b0;
		end
		return h;
	endfunction

endpackage

>>> sv/gtp_text_if.sv
// ----------------------------------------------------------------------------
// gtp_text_if
// Valid/ready channel that carries one character of GUID text per word.
// ----------------------------------------------------------------------------
interface gtp_text_if;
	logic       valid;
	logic       ready;
	logic       start_req;
	logic [7:0] char_code;

	modport source (output valid, output start_req, output char_code, input ready);
	modport sink   (input valid, input start_req, input char_code, output ready);
endinterface

>>> sv/gtp_guid_if.sv
// ----------------------------------------------------------------------------
// gtp_guid_if
// Valid/ready channel that carries one parsed GUID with its status per word.
// ----------------------------------------------------------------------------
interface gtp_guid_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [31:0] data1;
	logic [15:0] data2;
	logic [15:0] data3;
	logic [63:0] data4;

	modport source (output valid, output status, output data1, output data2,
		output data3, output data4, input ready);
	modport sink   (input valid, input status, input data1, input data2,
		input data3, input data4, output ready);
endinterface

>>> sv/guid_text_parser.sv
// ----------------------------------------------------------------------------
// guid_text_parser
// Streaming parser of 8-4-4-4-12 GUID text into its binary fields.
// ----------------------------------------------------------------------------
// The parser takes one character per clock cycle unless its input stalls, and the result
// of a string appears on the output channel in the cycle after the character
// that completes or breaks it. The parse state is held in registers updated
// once per accepted word, and the result sits in a single output register that
// is refilled in the same cycle it is taken, so input stalls only while a
// result waits and the output side is not ready.
module guid_text_parser (
	input  logic   clk,
	input  logic   arst_n,
	gtp_text_if.sink   text,
	gtp_guid_if.source guid
);
	import gtp_pkg::*;

	gtp_state_t  state_q;
	gtp_state_t  state_next;
	gtp_result_t step_result;
	gtp_result_t res_q;
	logic        step_emit;
	logic        res_valid_q;
	logic        text_acc;

	gtp_step u_step (
		.state      (state_q),
		.start_req  (text.start_req),
		.char_code  (text.char_code),
		.state_next (state_next),
		.emit       (step_emit),
		.result     (step_result)
	);

	assign text.ready = !res_valid_q || guid.ready;
	assign text_acc   = text.valid && text.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (text_acc) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (text_acc && step_emit) begin
			res_valid_q <= 1'b1;
		end else if (guid.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text_acc && step_emit) begin
			res_q <= step_result;
		end
	end

	assign guid.valid  = res_valid_q;
	assign guid.status = res_q.status;
	assign guid.data1  = res_q.data1;
	assign guid.data2  = res_q.data2;
	assign guid.data3  = res_q.data3;
	assign guid.data4  = res_q.data4;

	a_group_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.group_index <= GRP_NODE)
		else $error("group index out of range");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.digit_count <= NEED_NODE)
		else $error("digit count out of range");

	a_idle_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		(text_acc && step_emit) |=> (!state_q.busy && res_valid_q))
		else $error("parser still busy after giving a result");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_q.status == STATUS_INVALID)) |->
		(res_q.data1 == 32'd0 && res_q.data2 == 16'd0 && res_q.data3 == 16'd0
		&& res_q.data4 == 64'd0))
		else $error("invalid result carries nonzero fields");

endmodule

>>> sv/gtp_step.sv
// ----------------------------------------------------------------------------
// gtp_step
// Next-state logic of the parser for one character: digit decode, shift into
// the current field, prefix and dash handling, and the end-of-string result.
// ----------------------------------------------------------------------------
module gtp_step (
	input  gtp_pkg::gtp_state_t  state,
	input  logic                 start_req,
	input  logic [7:0]           char_code,
	output gtp_pkg::gtp_state_t  state_next,
	output logic                 emit,
	output gtp_pkg::gtp_result_t result
);
	import gtp_pkg::*;

	gtp_state_t  cur;
	gtp_hex_t    hex;
	logic [3:0]  need;
	logic [31:0] acc_now;
	logic        take_digit;
	logic        take_prefix;
	logic        take_dash;

	always_comb begin
		cur = state;
		if (start_req) begin
			cur = '0;
			cur.busy = 1'b1;
		end
	end

	always_comb begin
		case (cur.group_index)
			GRP_DATA1: need = NEED_DATA1;
			GRP_NODE:  need = NEED_NODE;
			default:   need = NEED_SHORT;
		endcase
		if (cur.prefix_seen) begin
			need = need - PREFIX_LEN;
		end
	end

	always_comb begin
		case (cur.group_index)
			GRP_DATA1: acc_now = cur.field1_acc;
			GRP_DATA2: acc_now = {16'd0, cur.field2_acc};
			default:   acc_now = {16'd0, cur.field3_acc};
		endcase
	end

	assign hex         = hex_decode(char_code);
	assign take_digit  = hex.valid && (cur.digit_count < need);
	assign take_prefix = (char_code == CHAR_LC_X) && (cur.group_index < GRP_CLOCK)
		&& !cur.prefix_seen && (cur.digit_count == 4'd1) && (acc_now == 32'd0);
	assign take_dash   = (char_code == CHAR_DASH) && (cur.group_index < GRP_NODE)
		&& (cur.digit_count == need);

	always_comb begin
		state_next = cur;
		emit       = 1'b0;
		result     = '0;
		result.status = STATUS_INVALID;
		if (cur.busy) begin
			if (take_digit) begin
				case (cur.group_index)
					GRP_DATA1: state_next.field1_acc = {cur.field1_acc[27:0], hex.value};
					GRP_DATA2: state_next.field2_acc = {cur.field2_acc[11:0], hex.value};
					GRP_DATA3: state_next.field3_acc = {cur.field3_acc[11:0], hex.value};
					default:   state_next.field4_acc = {cur.field4_acc[59:0], hex.value};
				endcase
				state_next.digit_count = cur.digit_count + 4'd1;
				if ((cur.group_index == GRP_NODE) && (cur.digit_count == NEED_NODE - 4'd1)) begin
					state_next.busy = 1'b0;
					emit            = 1'b1;
					result.status   = STATUS_OK;
					result.data1    = cur.field1_acc;
					result.data2    = cur.field2_acc;
					result.data3    = cur.field3_acc;
					result.data4    = {cur.field4_acc[59:0], hex.value};
				end
			end else if (take_prefix) begin
				state_next.prefix_seen = 1'b1;
				state_next.digit_count = 4'd0;
			end else if (take_dash) begin
				state_next.group_index = cur.group_index + 3'd1;
				state_next.digit_count = 4'd0;
				state_next.prefix_seen = 1'b0;
			end else begin
				state_next.busy = 1'b0;
				emit            = 1'b1;
			end
		end
	end

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the streaming GUID text parser. Each text word
// sent to the parser goes through a local parse model, and every GUID that
// the parser returns is checked field by field against the oldest prediction.
// The run starts with directed strings, then random strings under changing
// amounts of input idling and output stalling, and then a long output hold.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import gtp_pkg::*;

	localparam logic [7:0] CHAR_UC_X     = 8'h58;
	localparam logic [7:0] CHAR_NUL      = 8'h00;
	localparam int         HOLD_CYCLES   = 300;
	localparam int         CHARS_PER_RUN = 160;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	gtp_text_if text_ch ();
	gtp_guid_if guid_ch ();

	guid_text_parser i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.guid   (guid_ch)
	);

	always #1 clk = ~clk;

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int chars_sent    = 0;
	int error_count   = 0;
	logic hold_req    = 1'b0;
	logic hold_taken  = 1'b0;
	int hold_left     = 0;

	gtp_result_t expected_guids [$];
	logic [7:0]  text_buf [$];

	logic [2:0]  p_group;
	logic [3:0]  p_digits;
	logic        p_prefix;
	logic        p_busy = 1'b0;
	logic [31:0] p_data1;
	logic [15:0] p_data2;
	logic [15:0] p_data3;
	logic [63:0] p_data4;

	function automatic bit parse_guid_char(input logic st, input logic [7:0] c,
		output gtp_result_t res);
		logic [3:0]  need;
		logic [3:0]  nib;
		logic        is_hex;
		logic [31:0] acc;
		res = '0;
		if (st) begin
			p_group  = GRP_DATA1;
			p_digits = '0;
			p_prefix = 1'b0;
			p_data1  = '0;
			p_data2  = '0;
			p_data3  = '0;
			p_data4  = '0;
			p_busy   = 1'b1;
		end
		if (!p_busy) begin
			return 1'b0;
		end
		if (p_group == GRP_NODE) begin
			need = NEED_NODE;
		end else if (p_group == GRP_DATA1) begin
			need = NEED_DATA1;
		end else begin
			need = NEED_SHORT;
		end
		if (p_prefix) begin
			need = need - PREFIX_LEN;
		end
		is_hex = 1'b1;
		nib    = c[3:0];
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			nib = c[3:0];
		end else if ((c >= CHAR_LC_A && c <= CHAR_LC_F) ||
			(c >= CHAR_UC_A && c <= CHAR_UC_F)) begin
			nib = c[3:0] + 4'd9;
		end else begin
			is_hex = 1'b0;
		end
		if (is_hex && p_digits < need) begin
			case (p_group)
				GRP_DATA1: p_data1 = {p_data1[27:0], nib};
				GRP_DATA2: p_data2 = {p_data2[11:0], nib};
				GRP_DATA3: p_data3 = {p_data3[11:0], nib};
				default:   p_data4 = {p_data4[59:0], nib};
			endcase
			p_digits = p_digits + 4'd1;
			if (p_group == GRP_NODE && p_digits == NEED_NODE) begin
				p_busy     = 1'b0;
				res.status = STATUS_OK;
				res.data1  = p_data1;
				res.data2  = p_data2;
				res.data3  = p_data3;
				res.data4  = p_data4;
				return 1'b1;
			end
			return 1'b0;
		end
		if (c == CHAR_LC_X && p_group < GRP_CLOCK && !p_prefix && p_digits == 4'd1) begin
			if (p_group == GRP_DATA1) begin
				acc = p_data1;
			end else if (p_group == GRP_DATA2) begin
				acc = {16'd0, p_data2};
			end else begin
				acc = {16'd0, p_data3};
			end
			if (acc == '0) begin
				p_prefix = 1'b1;
				p_digits = '0;
				return 1'b0;
			end
		end
		if (c == CHAR_DASH && p_group < GRP_NODE && p_digits == need) begin
			p_group  = p_group + 3'd1;
			p_digits = '0;
			p_prefix = 1'b0;
			return 1'b0;
		end
		p_busy     = 1'b0;
		res.status = STATUS_INVALID;
		return 1'b1;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
		if (v < 4'd10) begin
			return CHAR_ZERO + 8'(v);
		end
		return (upper ? CHAR_UC_A : CHAR_LC_A) + 8'(v - 4'd10);
	endfunction

	function automatic logic [7:0] near_miss_char();
		case ($urandom_range(9))
			0:       return CHAR_ZERO - 8'd1;
			1:       return CHAR_NINE + 8'd1;
			2:       return CHAR_UC_A - 8'd1;
			3:       return CHAR_UC_F + 8'd1;
			4:       return CHAR_LC_A - 8'd1;
			5:       return CHAR_LC_F + 8'd1;
			6:       return CHAR_LC_X;
			7:       return CHAR_UC_X;
			8:       return CHAR_DASH;
			default: return CHAR_NUL;
		endcase
	endfunction

	task automatic send_char(input logic st, input logic [7:0] c);
		gtp_result_t res;
		bit          counted;
		text_ch.valid     <= 1'b1;
		text_ch.start_req <= st;
		text_ch.char_code <= c;
		@(posedge clk);
		while (!text_ch.ready) begin
			@(posedge clk);
		end
		counted = st || p_busy;
		if (parse_guid_char(st, c, res)) begin
			expected_guids.push_back(res);
		end
		if (counted) begin
			chars_sent++;
		end
		if ($urandom_range(99) < send_idle_pct) begin
			text_ch.valid <= 1'b0;
			do begin
				@(posedge clk);
			end while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_char(i == 0, s[i]);
		end
	endtask

	task automatic send_buf();
		for (int i = 0; i < text_buf.size(); i++) begin
			send_char(i == 0, text_buf[i]);
		end
	endtask

	task automatic build_guid_text(input logic [127:0] v, input logic [2:0] pfx,
		input int case_mode);
		int lens [5] = '{8, 4, 4, 4, 12};
		int k;
		int j0;
		text_buf.delete();
		k = 31;
		for (int g = 0; g < 5; g++) begin
			if (g > 0) begin
				text_buf.push_back(CHAR_DASH);
			end
			j0 = 0;
			if (g < 3 && pfx[g]) begin
				text_buf.push_back(CHAR_ZERO);
				text_buf.push_back(CHAR_LC_X);
				k  = k - 2;
				j0 = 2;
			end
			for (int j = j0; j < lens[g]; j++) begin
				text_buf.push_back(hex_char(v[4*k +: 4],
					case_mode == 2 ? bit'($urandom_range(1)) : case_mode == 1));
				k--;
			end
		end
	endtask

	task automatic send_random_text();
		logic [127:0] v;
		logic [2:0]   pfx;
		int           sel;
		int           pos;
		int           n;
		sel = $urandom_range(99);
		if (sel < 6) begin
			n = $urandom_range(1, 4);
			repeat (n) send_char(1'b0, 8'($urandom_range(255)));
		end else if (sel < 14) begin
			n = $urandom_range(0, 3);
			send_char(1'b1, ($urandom_range(1) == 1) ? 8'($urandom_range(255)) : near_miss_char());
			repeat (n) send_char(1'b0, 8'($urandom_range(255)));
		end else begin
			v = {$urandom, $urandom, $urandom, $urandom};
			for (int g = 0; g < 3; g++) begin
				pfx[g] = ($urandom_range(3) == 0);
			end
			build_guid_text(v, pfx, $urandom_range(2));
			if ($urandom_range(99) < 35) begin
				pos = $urandom_range(text_buf.size() - 1);
				case ($urandom_range(4))
					0:       text_buf[pos] = 8'($urandom_range(255));
					1:       text_buf[pos] = near_miss_char();
					2:       text_buf.insert(pos, hex_char(4'($urandom_range(15)),
						bit'($urandom_range(1))));
					3:       text_buf.delete(pos);
					default: text_buf[pos] = CHAR_NUL;
				endcase
			end
			send_buf();
			if ($urandom_range(99) < 25) begin
				n = $urandom_range(1, 3);
				repeat (n) send_char(1'b0, 8'($urandom_range(255)));
			end
		end
	endtask

	task automatic wait_results_drained();
		text_ch.valid <= 1'b0;
		while (expected_guids.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		stall_pct     = 0;
		send_char(1'b0, CHAR_LC_A);
		send_char(1'b0, CHAR_NUL);
		send_text("00000000-0000-0000-0000-000000000000");
		send_text("ffffffff-ffff-ffff-ffff-ffffffffffff");
		send_text("FFFFFFFF-FFFF-FFFF-FFFF-FFFFFFFFFFFF");
		send_text("0x123456-0x9A-0xbC-dEf0-123456789abc");
		send_text("0X123456-0000-0000-0000-000000000000");
		send_text("1x234567");
		send_text("0x0x1234");
		send_text("00x12345");
		send_text("12345678-1234-5678-0x12-000000000000");
		send_text("123456789");
		send_text("1234567-");
		send_text("0x12345-0000");
		send_text("12345678-12");
		send_char(1'b0, CHAR_NUL);
		send_text("-");
		send_char(1'b1, CHAR_NUL);
		send_char(1'b1, 8'hff);
		send_text("g/:@`G");
		send_text("12345678-1234-5678-9abc-def01234567-");
		send_text("1234");
		send_text("fedcba98-7654-3210-0123-456789ABCDEF");
		send_text("zz-x");
		wait_results_drained();
	endtask

	task automatic test_random_phase(input int idle_pct, input int stall);
		int target;
		send_idle_pct = idle_pct;
		stall_pct     = stall;
		target        = chars_sent + CHARS_PER_RUN;
		while (chars_sent < target) begin
			send_random_text();
		end
		wait_results_drained();
	endtask

	task automatic test_output_holdoff();
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_req     <= 1'b1;
		repeat (6) send_text("g");
		repeat (3) send_random_text();
		send_text("0xabcdef-0x12-0x34-5678-9abcdef01234");
		wait_results_drained();
	endtask

	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken    <= 1'b1;
			hold_left     <= HOLD_CYCLES;
			guid_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left     <= hold_left - 1;
			guid_ch.ready <= 1'b0;
		end else begin
			guid_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		gtp_result_t exp_r;
		if (guid_ch.valid === 1'b1 && guid_ch.ready === 1'b1) begin
			if (expected_guids.size() == 0) begin
				$error("unexpected result: status %0h, data1 %h", guid_ch.status, guid_ch.data1);
				error_count++;
			end else begin
				exp_r = expected_guids.pop_front();
				if (guid_ch.status !== exp_r.status) begin
					$error("status mismatch: expected %0h, actual %0h", exp_r.status,
						guid_ch.status);
					error_count++;
				end
				if (guid_ch.data1 !== exp_r.data1) begin
					$error("data1 mismatch: expected %h, actual %h", exp_r.data1, guid_ch.data1);
					error_count++;
				end
				if (guid_ch.data2 !== exp_r.data2) begin
					$error("data2 mismatch: expected %h, actual %h", exp_r.data2, guid_ch.data2);
					error_count++;
				end
				if (guid_ch.data3 !== exp_r.data3) begin
					$error("data3 mismatch: expected %h, actual %h", exp_r.data3, guid_ch.data3);
					error_count++;
				end
				if (guid_ch.data4 !== exp_r.data4) begin
					$error("data4 mismatch: expected %h, actual %h", exp_r.data4, guid_ch.data4);
					error_count++;
				end
			end
		end
	end

	initial begin
		text_ch.valid     = 1'b0;
		text_ch.start_req = 1'b0;
		text_ch.char_code = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_phase(0, 0);
		test_random_phase(87, 0);
		test_random_phase(0, 87);
		test_random_phase(38, 38);
		test_output_holdoff();
		wait_results_drained();
		repeat (20) @(posedge clk);
		if (error_count == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

	initial begin
		#400us;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
